// ===== sv/trwe_pkg.sv =====
// ---------------------------------------------------------------------------
// trwe_pkg
// Shared codes and control types for the trapped random walk engine.
// ---------------------------------------------------------------------------
package trwe_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PLACE = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] DIR_COL_DEC = 2'd0;
  localparam logic [1:0] DIR_ROW_INC = 2'd1;
  localparam logic [1:0] DIR_COL_INC = 2'd2;
  localparam logic [1:0] DIR_ROW_DEC = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_LIMIT   = 2'd2;

  localparam logic [9:0] SIDE_RESET = 10'd500;

  typedef struct packed {
    logic accept;
    logic finish;
    logic sweep;
    logic sweep_hist;
  } trwe_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic op_clear;
  } trwe_stat_t;

endpackage

// ===== sv/trapped_random_walk_engine_core.sv =====
// ---------------------------------------------------------------------------
// trapped_random_walk_engine_core
// Lattice walker with a trap map and trapping-time / survival histograms.
//
//   channel  | handshake           | beat accepted when
//   ---------+---------------------+-------------------------------
//   in_      | start / busy        | start high and busy low
//   out_     | out_valid strobe    | end of the one-cycle strobe
//   cfg_     | cfg_valid/cfg_ready | both high (side in use)
//
// for place, step and read the trap map row and both histogram bins are read
// at the accept edge; the result and write-back follow in the execute state.
// clear sweeps the trap map, one trap map row cleared per cycle.
// after reset busy stays high while the
// map and histograms are cleared through their single write ports.
// the receiver cannot stall; a new command may start in the strobe cycle.
// ---------------------------------------------------------------------------
module trapped_random_walk_engine_core import trwe_pkg::*; #(
  parameter int GRID_SIDE = 512,
  parameter int MAX_STEPS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [8:0]  in_trap_row,
  input  logic [8:0]  in_trap_col,
  input  logic [1:0]  in_direction,
  input  logic [9:0]  in_bin_index,
  input  logic        in_which_histogram,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_side_in_use,
  output logic        out_valid,
  output logic        out_trapped,
  output logic [9:0]  out_step_count,
  output logic [18:0] out_trap_total,
  output logic [31:0] out_bin_value,
  output logic [9:0]  out_longest_walk,
  output logic [9:0]  out_longest_survival,
  output logic [1:0]  out_status
);

  trwe_cmd_t  cmd;
  trwe_stat_t stat;

  assign cfg_ready = 1'b1;

  trwe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  trwe_datapath #(
    .GRID_SIDE (GRID_SIDE),
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_op                (in_op),
    .in_trap_row          (in_trap_row),
    .in_trap_col          (in_trap_col),
    .in_direction         (in_direction),
    .in_bin_index         (in_bin_index),
    .in_which_histogram   (in_which_histogram),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_side_in_use      (cfg_side_in_use),
    .out_valid            (out_valid),
    .out_trapped          (out_trapped),
    .out_step_count       (out_step_count),
    .out_trap_total       (out_trap_total),
    .out_bin_value        (out_bin_value),
    .out_longest_walk     (out_longest_walk),
    .out_longest_survival (out_longest_survival),
    .out_status           (out_status)
  );

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_result_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  a_trapped_status : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trapped) |-> (out_status != STATUS_REFUSED))
    else $error("trapped step reported as refused");

endmodule

// ===== sv/trwe_ctrl.sv =====
// ---------------------------------------------------------------------------
// trwe_ctrl
// Sequencer: start-up clearing sweep, command accept, execute and map clear.
// ---------------------------------------------------------------------------
module trwe_ctrl import trwe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  trwe_stat_t stat,
  output trwe_cmd_t  cmd
);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_INIT: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_hist = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op_clear) begin
          state_nxt = S_SWEEP;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/trwe_datapath.sv =====
// ---------------------------------------------------------------------------
// trwe_datapath
// Walker position, trap map and histogram memories, counters and result beat.
// ---------------------------------------------------------------------------
module trwe_datapath import trwe_pkg::*; #(
  parameter int GRID_SIDE = 512,
  parameter int MAX_STEPS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  trwe_cmd_t   cmd,
  output trwe_stat_t  stat,
  input  logic [1:0]  in_op,
  input  logic [8:0]  in_trap_row,
  input  logic [8:0]  in_trap_col,
  input  logic [1:0]  in_direction,
  input  logic [9:0]  in_bin_index,
  input  logic        in_which_histogram,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_side_in_use,
  output logic        out_valid,
  output logic        out_trapped,
  output logic [9:0]  out_step_count,
  output logic [18:0] out_trap_total,
  output logic [31:0] out_bin_value,
  output logic [9:0]  out_longest_walk,
  output logic [9:0]  out_longest_survival,
  output logic [1:0]  out_status
);

  localparam int RW      = $clog2(GRID_SIDE);
  localparam int SW      = $clog2(GRID_SIDE + 1);
  localparam int NW      = $clog2(MAX_STEPS);
  localparam int TW      = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int SWEEP_N = (GRID_SIDE > MAX_STEPS) ? GRID_SIDE : MAX_STEPS;
  localparam int CLW     = $clog2(SWEEP_N);
  localparam int RST_SIDE = (GRID_SIDE < 500) ? GRID_SIDE : 500;
  localparam int RST_CTR  = RST_SIDE / 2 - 1;
  localparam logic [NW-1:0] LAST_STEP = NW'(MAX_STEPS - 1);

  logic [GRID_SIDE-1:0] map_mem [GRID_SIDE];
  logic [31:0]          trap_hist_mem [MAX_STEPS];
  logic [31:0]          surv_hist_mem [MAX_STEPS];

  logic [9:0]    side_r;
  logic [RW-1:0] row_r, col_r, row_nxt, col_nxt;
  logic [NW-1:0] steps_r, steps_nxt;
  logic [TW-1:0] trap_cnt_r, trap_cnt_nxt;
  logic [NW-1:0] max_walk_r, max_walk_nxt;
  logic [NW-1:0] max_free_r, max_free_nxt;
  logic [CLW-1:0] sweep_cnt_r;

  logic [1:0]    op_r;
  logic [RW-1:0] rd_row_r, rd_col_r;
  logic [NW-1:0] t_r;
  logic          limit_r, place_bad_r, bin_bad_r, which_r;
  logic [GRID_SIDE-1:0] map_rd_r;
  logic [31:0]   trap_rd_r, surv_rd_r;

  logic          out_valid_r, out_trapped_r;
  logic [9:0]    out_step_count_r, out_longest_walk_r, out_longest_survival_r;
  logic [18:0]   out_trap_total_r;
  logic [31:0]   out_bin_value_r;
  logic [1:0]    out_status_r;

  logic [SW-1:0] eff_side;
  logic [RW-1:0] centre;
  logic [RW-1:0] mv_row, mv_col;
  logic [NW-1:0] t_nxt;
  logic          place_bad;
  logic [RW-1:0] map_raddr;
  logic [NW-1:0] hist_raddr;
  logic          sweep_last;
  logic          map_hit, place_refused;
  logic          map_we;
  logic [RW-1:0] map_waddr;
  logic [GRID_SIDE-1:0] map_wdata;
  logic          trap_we, surv_we;
  logic [NW-1:0] hist_waddr;
  logic [31:0]   hist_src, hist_wdata;
  logic          res_trapped;
  logic [NW-1:0] res_count;
  logic [31:0]   res_bin;
  logic [1:0]    res_status;

  // lattice geometry
  always_comb begin
    if (side_r < 10'd4) begin
      eff_side = SW'(4);
    end else if (32'(side_r) > 32'(GRID_SIDE)) begin
      eff_side = SW'(GRID_SIDE);
    end else begin
      eff_side = SW'(side_r);
    end
    centre = RW'((eff_side >> 1) - SW'(1));
  end

  // candidate move and step count
  always_comb begin
    mv_row = row_r;
    mv_col = col_r;
    case (in_direction)
      DIR_COL_DEC: begin
        if (col_r > RW'(1)) mv_col = col_r - RW'(1);
      end
      DIR_ROW_INC: begin
        if (SW'(row_r) + SW'(1) < eff_side) mv_row = row_r + RW'(1);
      end
      DIR_COL_INC: begin
        if (SW'(col_r) + SW'(1) < eff_side) mv_col = col_r + RW'(1);
      end
      DIR_ROW_DEC: begin
        if (row_r > RW'(1)) mv_row = row_r - RW'(1);
      end
      default: begin
        mv_row = row_r;
      end
    endcase
    t_nxt = (steps_r < LAST_STEP) ? steps_r + NW'(1) : steps_r;
    place_bad = (32'(in_trap_row) >= 32'(eff_side)) ||
                (32'(in_trap_col) >= 32'(eff_side)) ||
                (RW'(in_trap_row) == centre && RW'(in_trap_col) == centre);
    map_raddr  = (in_op == OP_STEP) ? mv_row : RW'(in_trap_row);
    hist_raddr = (in_op == OP_STEP) ? t_nxt : NW'(in_bin_index);
  end

  // clearing sweep
  always_comb begin
    if (cmd.sweep_hist) begin
      sweep_last = (sweep_cnt_r == CLW'(SWEEP_N - 1));
    end else begin
      sweep_last = (sweep_cnt_r == CLW'(GRID_SIDE - 1));
    end
  end

  assign stat.sweep_last = sweep_last;
  assign stat.op_clear   = (op_r == OP_CLEAR);

  assign map_hit       = map_rd_r[rd_col_r];
  assign place_refused = place_bad_r || map_hit;

  // memory write ports
  always_comb begin
    map_we    = 1'b0;
    map_waddr = rd_row_r;
    map_wdata = map_rd_r | ({{(GRID_SIDE-1){1'b0}}, 1'b1} << rd_col_r);
    if (cmd.sweep) begin
      map_we    = (32'(sweep_cnt_r) < 32'(GRID_SIDE));
      map_waddr = RW'(sweep_cnt_r);
      map_wdata = '0;
    end else if (cmd.finish && op_r == OP_PLACE && !place_refused) begin
      map_we = 1'b1;
    end

    hist_src   = map_hit ? trap_rd_r : surv_rd_r;
    hist_wdata = (hist_src == 32'hFFFF_FFFF) ? hist_src : hist_src + 32'd1;
    hist_waddr = t_r;
    trap_we    = 1'b0;
    surv_we    = 1'b0;
    if (cmd.sweep) begin
      trap_we    = cmd.sweep_hist && (32'(sweep_cnt_r) < 32'(MAX_STEPS));
      surv_we    = trap_we;
      hist_waddr = NW'(sweep_cnt_r);
      hist_wdata = '0;
    end else if (cmd.finish && op_r == OP_STEP) begin
      trap_we = map_hit;
      surv_we = !map_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (cmd.accept) map_rd_r <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (trap_we) trap_hist_mem[hist_waddr] <= hist_wdata;
    if (cmd.accept) trap_rd_r <= trap_hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (surv_we) surv_hist_mem[hist_waddr] <= hist_wdata;
    if (cmd.accept) surv_rd_r <= surv_hist_mem[hist_raddr];
  end

  // outcome of the command
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    steps_nxt    = steps_r;
    trap_cnt_nxt = trap_cnt_r;
    max_walk_nxt = max_walk_r;
    max_free_nxt = max_free_r;
    res_trapped  = 1'b0;
    res_count    = steps_r;
    res_bin      = '0;
    res_status   = STATUS_OK;
    if (cmd.finish) begin
      case (op_r)
        OP_CLEAR: begin
          row_nxt      = centre;
          col_nxt      = centre;
          steps_nxt    = '0;
          trap_cnt_nxt = '0;
          res_count    = '0;
        end
        OP_PLACE: begin
          if (place_refused) begin
            res_status = STATUS_REFUSED;
          end else begin
            trap_cnt_nxt = trap_cnt_r + TW'(1);
          end
        end
        OP_STEP: begin
          res_count = t_r;
          if (limit_r) res_status = STATUS_LIMIT;
          if (map_hit) begin
            res_trapped = 1'b1;
            row_nxt     = centre;
            col_nxt     = centre;
            steps_nxt   = '0;
            if (t_r > max_walk_r) max_walk_nxt = t_r;
          end else begin
            row_nxt   = rd_row_r;
            col_nxt   = rd_col_r;
            steps_nxt = t_r;
            if (t_r > max_free_r) max_free_nxt = t_r;
          end
        end
        OP_READ: begin
          if (bin_bad_r) begin
            res_status = STATUS_REFUSED;
          end else begin
            res_bin = which_r ? surv_rd_r : trap_rd_r;
          end
        end
        default: begin
          res_status = STATUS_OK;
        end
      endcase
    end
  end

  // command capture and result beat registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r        <= in_op;
      rd_row_r    <= map_raddr;
      rd_col_r    <= (in_op == OP_STEP) ? mv_col : RW'(in_trap_col);
      t_r         <= t_nxt;
      limit_r     <= (t_nxt == LAST_STEP);
      place_bad_r <= place_bad;
      bin_bad_r   <= (32'(in_bin_index) >= 32'(MAX_STEPS));
      which_r     <= in_which_histogram;
    end
    if (cmd.finish) begin
      out_trapped_r          <= res_trapped;
      out_step_count_r       <= 10'(res_count);
      out_trap_total_r       <= 19'(trap_cnt_nxt);
      out_bin_value_r        <= res_bin;
      out_longest_walk_r     <= 10'(max_walk_nxt);
      out_longest_survival_r <= 10'(max_free_nxt);
      out_status_r           <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= SIDE_RESET;
      row_r       <= RW'(RST_CTR);
      col_r       <= RW'(RST_CTR);
      steps_r     <= '0;
      trap_cnt_r  <= '0;
      max_walk_r  <= '0;
      max_free_r  <= NW'(1);
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) side_r <= cfg_side_in_use;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      steps_r     <= steps_nxt;
      trap_cnt_r  <= trap_cnt_nxt;
      max_walk_r  <= max_walk_nxt;
      max_free_r  <= max_free_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.sweep) begin
        sweep_cnt_r <= sweep_last ? '0 : sweep_cnt_r + CLW'(1);
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_trapped          = out_trapped_r;
  assign out_step_count       = out_step_count_r;
  assign out_trap_total       = out_trap_total_r;
  assign out_bin_value        = out_bin_value_r;
  assign out_longest_walk     = out_longest_walk_r;
  assign out_longest_survival = out_longest_survival_r;
  assign out_status           = out_status_r;

endmodule
